>>> design/sm4_pkg.sv
// Package with SM4 constants, S-box and round helper functions.
`timescale 1ns / 1ps
package sm4_pkg;

    localparam int NumRounds = 32;
    localparam int RoundBits = 5;
    localparam int KeyRegBits = 2;

    localparam logic [1:0] CFG_KEY_WORD_0 = 2'd0;
    localparam logic [1:0] CFG_KEY_WORD_1 = 2'd1;
    localparam logic [1:0] CFG_KEY_WORD_2 = 2'd2;
    localparam logic [1:0] CFG_KEY_WORD_3 = 2'd3;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    typedef logic [127:0] state_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r = 8'hd6; 8'h01: r = 8'h90; 8'h02: r = 8'he9; 8'h03: r = 8'hfe;
            8'h04: r = 8'hcc; 8'h05: r = 8'he1; 8'h06: r = 8'h3d; 8'h07: r = 8'hb7;
            8'h08: r = 8'h16; 8'h09: r = 8'hb6; 8'h0a: r = 8'h14; 8'h0b: r = 8'hc2;
            8'h0c: r = 8'h28; 8'h0d: r = 8'hfb; 8'h0e: r = 8'h2c; 8'h0f: r = 8'h05;
            8'h10: r = 8'h2b; 8'h11: r = 8'h67; 8'h12: r = 8'h9a; 8'h13: r = 8'h76;
            8'h14: r = 8'h2a; 8'h15: r = 8'hbe; 8'h16: r = 8'h04; 8'h17: r = 8'hc3;
            8'h18: r = 8'haa; 8'h19: r = 8'h44; 8'h1a: r = 8'h13; 8'h1b: r = 8'h26;
            8'h1c: r = 8'h49; 8'h1d: r = 8'h86; 8'h1e: r = 8'h06; 8'h1f: r = 8'h99;
            8'h20: r = 8'h9c; 8'h21: r = 8'h42; 8'h22: r = 8'h50; 8'h23: r = 8'hf4;
            8'h24: r = 8'h91; 8'h25: r = 8'hef; 8'h26: r = 8'h98; 8'h27: r = 8'h7a;
            8'h28: r = 8'h33; 8'h29: r = 8'h54; 8'h2a: r = 8'h0b; 8'h2b: r = 8'h43;
            8'h2c: r = 8'hed; 8'h2d: r = 8'hcf; 8'h2e: r = 8'hac; 8'h2f: r = 8'h62;
            8'h30: r = 8'he4; 8'h31: r = 8'hb3; 8'h32: r = 8'h1c; 8'h33: r = 8'ha9;
            8'h34: r = 8'hc9; 8'h35: r = 8'h08; 8'h36: r = 8'he8; 8'h37: r = 8'h95;
            8'h38: r = 8'h80; 8'h39: r = 8'hdf; 8'h3a: r = 8'h94; 8'h3b: r = 8'hfa;
            8'h3c: r = 8'h75; 8'h3d: r = 8'h8f; 8'h3e: r = 8'h3f; 8'h3f: r = 8'ha6;
            8'h40: r = 8'h47; 8'h41: r = 8'h07; 8'h42: r = 8'ha7; 8'h43: r = 8'hfc;
            8'h44: r = 8'hf3; 8'h45: r = 8'h73; 8'h46: r = 8'h17; 8'h47: r = 8'hba;
            8'h48: r = 8'h83; 8'h49: r = 8'h59; 8'h4a: r = 8'h3c; 8'h4b: r = 8'h19;
            8'h4c: r = 8'he6; 8'h4d: r = 8'h85; 8'h4e: r = 8'h4f; 8'h4f: r = 8'ha8;
            8'h50: r = 8'h68; 8'h51: r = 8'h6b; 8'h52: r = 8'h81; 8'h53: r = 8'hb2;
            8'h54: r = 8'h71; 8'h55: r = 8'h64; 8'h56: r = 8'hda; 8'h57: r = 8'h8b;
            8'h58: r = 8'hf8; 8'h59: r = 8'heb; 8'h5a: r = 8'h0f; 8'h5b: r = 8'h4b;
            8'h5c: r = 8'h70; 8'h5d: r = 8'h56; 8'h5e: r = 8'h9d; 8'h5f: r = 8'h35;
            8'h60: r = 8'h1e; 8'h61: r = 8'h24; 8'h62: r = 8'h0e; 8'h63: r = 8'h5e;
            8'h64: r = 8'h63; 8'h65: r = 8'h58; 8'h66: r = 8'hd1; 8'h67: r = 8'ha2;
            8'h68: r = 8'h25; 8'h69: r = 8'h22; 8'h6a: r = 8'h7c; 8'h6b: r = 8'h3b;
            8'h6c: r = 8'h01; 8'h6d: r = 8'h21; 8'h6e: r = 8'h78; 8'h6f: r = 8'h87;
            8'h70: r = 8'hd4; 8'h71: r = 8'h00; 8'h72: r = 8'h46; 8'h73: r = 8'h57;
            8'h74: r = 8'h9f; 8'h75: r = 8'hd3; 8'h76: r = 8'h27; 8'h77: r = 8'h52;
            8'h78: r = 8'h4c; 8'h79: r = 8'h36; 8'h7a: r = 8'h02; 8'h7b: r = 8'he7;
            8'h7c: r = 8'ha0; 8'h7d: r = 8'hc4; 8'h7e: r = 8'hc8; 8'h7f: r = 8'h9e;
            8'h80: r = 8'hea; 8'h81: r = 8'hbf; 8'h82: r = 8'h8a; 8'h83: r = 8'hd2;
            8'h84: r = 8'h40; 8'h85: r = 8'hc7; 8'h86: r = 8'h38; 8'h87: r = 8'hb5;
            8'h88: r = 8'ha3; 8'h89: r = 8'hf7; 8'h8a: r = 8'hf2; 8'h8b: r = 8'hce;
            8'h8c: r = 8'hf9; 8'h8d: r = 8'h61; 8'h8e: r = 8'h15; 8'h8f: r = 8'ha1;
            8'h90: r = 8'he0; 8'h91: r = 8'hae; 8'h92: r = 8'h5d; 8'h93: r = 8'ha4;
            8'h94: r = 8'h9b; 8'h95: r = 8'h34; 8'h96: r = 8'h1a; 8'h97: r = 8'h55;
            8'h98: r = 8'had; 8'h99: r = 8'h93; 8'h9a: r = 8'h32; 8'h9b: r = 8'h30;
            8'h9c: r = 8'hf5; 8'h9d: r = 8'h8c; 8'h9e: r = 8'hb1; 8'h9f: r = 8'he3;
            8'ha0: r = 8'h1d; 8'ha1: r = 8'hf6; 8'ha2: r = 8'he2; 8'ha3: r = 8'h2e;
            8'ha4: r = 8'h82; 8'ha5: r = 8'h66; 8'ha6: r = 8'hca; 8'ha7: r = 8'h60;
            8'ha8: r = 8'hc0; 8'ha9: r = 8'h29; 8'haa: r = 8'h23; 8'hab: r = 8'hab;
            8'hac: r = 8'h0d; 8'had: r = 8'h53; 8'hae: r = 8'h4e; 8'haf: r = 8'h6f;
            8'hb0: r = 8'hd5; 8'hb1: r = 8'hdb; 8'hb2: r = 8'h37; 8'hb3: r = 8'h45;
            8'hb4: r = 8'hde; 8'hb5: r = 8'hfd; 8'hb6: r = 8'h8e; 8'hb7: r = 8'h2f;
            8'hb8: r = 8'h03; 8'hb9: r = 8'hff; 8'hba: r = 8'h6a; 8'hbb: r = 8'h72;
            8'hbc: r = 8'h6d; 8'hbd: r = 8'h6c; 8'hbe: r = 8'h5b; 8'hbf: r = 8'h51;
            8'hc0: r = 8'h8d; 8'hc1: r = 8'h1b; 8'hc2: r = 8'haf; 8'hc3: r = 8'h92;
            8'hc4: r = 8'hbb; 8'hc5: r = 8'hdd; 8'hc6: r = 8'hbc; 8'hc7: r = 8'h7f;
            8'hc8: r = 8'h11; 8'hc9: r = 8'hd9; 8'hca: r = 8'h5c; 8'hcb: r = 8'h41;
            8'hcc: r = 8'h1f; 8'hcd: r = 8'h10; 8'hce: r = 8'h5a; 8'hcf: r = 8'hd8;
            8'hd0: r = 8'h0a; 8'hd1: r = 8'hc1; 8'hd2: r = 8'h31; 8'hd3: r = 8'h88;
            8'hd4: r = 8'ha5; 8'hd5: r = 8'hcd; 8'hd6: r = 8'h7b; 8'hd7: r = 8'hbd;
            8'hd8: r = 8'h2d; 8'hd9: r = 8'h74; 8'hda: r = 8'hd0; 8'hdb: r = 8'h12;
            8'hdc: r = 8'hb8; 8'hdd: r = 8'he5; 8'hde: r = 8'hb4; 8'hdf: r = 8'hb0;
            8'he0: r = 8'h89; 8'he1: r = 8'h69; 8'he2: r = 8'h97; 8'he3: r = 8'h4a;
            8'he4: r = 8'h0c; 8'he5: r = 8'h96; 8'he6: r = 8'h77; 8'he7: r = 8'h7e;
            8'he8: r = 8'h65; 8'he9: r = 8'hb9; 8'hea: r = 8'hf1; 8'heb: r = 8'h09;
            8'hec: r = 8'hc5; 8'hed: r = 8'h6e; 8'hee: r = 8'hc6; 8'hef: r = 8'h84;
            8'hf0: r = 8'h18; 8'hf1: r = 8'hf0; 8'hf2: r = 8'h7d; 8'hf3: r = 8'hec;
            8'hf4: r = 8'h3a; 8'hf5: r = 8'hdc; 8'hf6: r = 8'h4d; 8'hf7: r = 8'h20;
            8'hf8: r = 8'h79; 8'hf9: r = 8'hee; 8'hfa: r = 8'h5f; 8'hfb: r = 8'h3e;
            8'hfc: r = 8'hd7; 8'hfd: r = 8'hcb; 8'hfe: r = 8'h39; 8'hff: r = 8'h48;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] v);
        return {sbox(v[31:24]), sbox(v[23:16]), sbox(v[15:8]), sbox(v[7:0])};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // CK byte j of round i is (4*i + j) * 7 mod 256
    function automatic logic [31:0] ck_word(input logic [RoundBits-1:0] i);
        logic [7:0] b0;
        b0 = 8'({i, 2'b00}) * 8'd7;
        return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
    endfunction

endpackage

>>> design/sm4_block_encrypt.sv
// SM4 ECB encryption engine top level.
// A request taken goes through a prefetch state for the round key read, then 32 rounds
// through the single shared round unit, with the output register loaded by the last round,
// before m_tvalid rises. After reset or any key write the next block first runs 32 rounds
// of key expansion through the same unit into the round key memory. The block is
// not ready again until its result has been taken and it is back in idle, so it takes no
// new block before the last one is through. Write the key only while the block is idle.
`timescale 1ns / 1ps
module sm4_block_encrypt
    import sm4_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [KeyRegBits-1:0] cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // block_word_0 [31:0], block_word_1 [63:32], block_word_2 [95:64], block_word_3 [127:96]
    input  logic [127:0]          s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cipher_word_0 [31:0], cipher_word_1 [63:32], cipher_word_2 [95:64], cipher_word_3 [127:96]
    output logic [127:0]          m_tdata
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KEY  = 3'd1;
    localparam logic [2:0] ST_PRE  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [RoundBits-1:0] cnt_reg, cnt_next;
    logic                 ready_reg, ready_next;
    logic [31:0]          key_reg [4];
    state_t               x_reg, x_next;
    state_t               blk_reg, blk_next;
    logic [127:0]         out_reg, out_next;

    logic [31:0]          rk;
    logic [31:0]          mix;
    logic [31:0]          nw;
    logic                 key_mode;
    logic                 ram_we;
    logic [RoundBits-1:0] raddr;

    // x_reg words: [127:96]=x0 ... [31:0]=x3
    assign key_mode = (state_reg == ST_KEY);
    assign mix = x_reg[95:64] ^ x_reg[63:32] ^ x_reg[31:0] ^ (key_mode ? ck_word(cnt_reg) : rk);
    assign ram_we = key_mode;
    assign raddr = (state_reg == ST_RND) ? cnt_reg + 1'b1 : '0;

    sm4_round_unit u_round (.w0(x_reg[127:96]), .mix(mix), .key_mode(key_mode), .nw(nw));

    sm4_key_ram u_ram (
        .clk(clk), .we(ram_we), .waddr(cnt_reg), .wdata(nw), .raddr(raddr), .rdata(rk)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ready_next = ready_reg;
        x_next = x_reg;
        blk_next = blk_reg;
        out_next = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    blk_next = {s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tdata[127:96]};
                    cnt_next = '0;
                    if (ready_reg)
                    begin
                        x_next = blk_next;
                        state_next = ST_PRE;
                    end
                    else
                    begin
                        x_next = {key_reg[0] ^ FK0, key_reg[1] ^ FK1,
                                  key_reg[2] ^ FK2, key_reg[3] ^ FK3};
                        state_next = ST_KEY;
                    end
                end
            end
            ST_KEY:
            begin
                x_next = {x_reg[95:0], nw};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == RoundBits'(NumRounds - 1))
                begin
                    ready_next = 1'b1;
                    x_next = blk_reg;
                    state_next = ST_PRE;
                end
            end
            ST_PRE:
            begin
                // wait for round key 0 read
                cnt_next = '0;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                x_next = {x_reg[95:0], nw};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == RoundBits'(NumRounds - 1))
                begin
                    out_next = {x_reg[95:64], x_reg[63:32], x_reg[31:0], nw};
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_we)
            ready_next = 1'b0;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            ready_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                key_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            ready_reg <= ready_next;
            if (cfg_we)
                key_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        blk_reg <= blk_next;
        out_reg <= out_next;
    end

    a_key_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEY && cnt_reg == RoundBits'(NumRounds - 1) && !cfg_we) |=> ready_reg)
        else $error("keys not marked ready after expansion");
    a_pre_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRE) |=> (state_reg == ST_RND && cnt_reg == '0))
        else $error("round phase did not start at round zero");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped while stalled");
endmodule

>>> design/sm4_round_unit.sv
// Shared SM4 round unit: S-box layer and either the cipher or key-schedule linear map.
`timescale 1ns / 1ps
module sm4_round_unit
    import sm4_pkg::*;
(
    input  logic [31:0] w0,
    input  logic [31:0] mix,
    input  logic        key_mode,
    output logic [31:0] nw
);
    logic [31:0] t;

    always_comb
    begin
        t = sub_word(mix);
        if (key_mode)
            nw = w0 ^ t ^ rotl(t, 13) ^ rotl(t, 23);
        else
            nw = w0 ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
    end
endmodule

>>> design/sm4_key_ram.sv
// Round key store, 32 words, one write and one registered read port.
`timescale 1ns / 1ps
module sm4_key_ram
    import sm4_pkg::*;
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [RoundBits-1:0] waddr,
    input  logic [31:0]          wdata,
    input  logic [RoundBits-1:0] raddr,
    output logic [31:0]          rdata
);
    logic [31:0] mem [NumRounds];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> sim/tb.sv
// Self-checking testbench for the SM4 ECB encryption engine.
`timescale 1ns / 1ps
module tb
    import sm4_pkg::*;
();

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [KeyRegBits-1:0] cfg_index;
    logic [31:0]           cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // block_word_0 [31:0], block_word_1 [63:32], block_word_2 [95:64], block_word_3 [127:96]
    logic [127:0]          s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // cipher_word_0 [31:0], cipher_word_1 [63:32], cipher_word_2 [95:64], cipher_word_3 [127:96]
    logic [127:0]          m_tdata;

    sm4_block_encrypt dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    localparam logic [7:0] SBOX_TBL [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    localparam logic [31:0] FAMILY_KEY [4] = '{FK0, FK1, FK2, FK3};

    logic [31:0]  key_regs [4];
    logic [31:0]  round_key [32];
    logic [127:0] block_q [$];
    logic [127:0] cipher_q [$];
    int           errors;
    int           blocks_sent;
    int           blocks_checked;
    int           key_loads;
    int           burst_left;
    int           gap_left;
    int           stall_left;

    function automatic logic [31:0] tau(input logic [31:0] v);
        return {SBOX_TBL[v[31:24]], SBOX_TBL[v[23:16]], SBOX_TBL[v[15:8]], SBOX_TBL[v[7:0]]};
    endfunction

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] t;
        logic [31:0] ck;
        logic [31:0] nk;
        for (int i = 0; i < 4; i++)
        begin
            k[i] = key_regs[i] ^ FAMILY_KEY[i];
        end
        for (int i = 0; i < 32; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                ck[31 - 8 * j -: 8] = 8'((4 * i + j) * 7);
            end
            t = tau(k[1] ^ k[2] ^ k[3] ^ ck);
            nk = k[0] ^ t ^ rol32(t, 13) ^ rol32(t, 23);
            round_key[i] = nk;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
        end
    endtask

    // Word 0 of the plaintext sits in the low bits and is the first state word.
    function automatic logic [127:0] sm4_cipher(input logic [127:0] plain);
        logic [31:0] x [4];
        logic [31:0] t;
        logic [31:0] nw;
        for (int i = 0; i < 4; i++)
        begin
            x[i] = plain[32 * i +: 32];
        end
        for (int i = 0; i < 32; i++)
        begin
            t = tau(x[1] ^ x[2] ^ x[3] ^ round_key[i]);
            nw = x[0] ^ t ^ rol32(t, 2) ^ rol32(t, 10) ^ rol32(t, 18) ^ rol32(t, 24);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nw;
        end
        return {x[0], x[1], x[2], x[3]};
    endfunction

    always #5 clk = ~clk;

    // Driver: bursts of requests separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                cipher_q.push_back(sm4_cipher(s_tdata));
                void'(block_q.pop_front());
                blocks_sent++;
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the request until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (block_q.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= block_q[0];
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                end
                burst_left = burst_left - 1;
                if (burst_left == 0)
                begin
                    gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each result against the oldest prediction, stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b1;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (cipher_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (m_tdata[32 * i +: 32] !== cipher_q[0][32 * i +: 32])
                        begin
                            $display("%0t: cipher_word_%0d expected %h actual %h", $time, i,
                                     cipher_q[0][32 * i +: 32], m_tdata[32 * i +: 32]);
                            errors++;
                        end
                    end
                    void'(cipher_q.pop_front());
                end
                blocks_checked++;
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_tready <= (stall_left == 0);
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(1, 20);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        while (block_q.size() != 0 || cipher_q.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Write a set of key words back to back, then drop the enable.
    task automatic load_key(input logic [3:0] mask, input logic [127:0] key);
        for (int i = 0; i < 4; i++)
        begin
            if (mask[i])
            begin
                @(posedge clk);
                cfg_we    <= 1'b1;
                cfg_index <= KeyRegBits'(i);
                cfg_data  <= key[127 - 32 * i -: 32];
                key_regs[i] = key[127 - 32 * i -: 32];
            end
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        expand_round_keys();
        key_loads++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            block_q.push_back({rand_word(), rand_word(), rand_word(), rand_word()});
        end
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_KEY_WORD_0;
        cfg_data  = '0;
        errors         = 0;
        blocks_sent    = 0;
        blocks_checked = 0;
        key_loads      = 0;
        for (int i = 0; i < 4; i++)
        begin
            key_regs[i] = '0;
        end
        expand_round_keys();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // blocks under the reset key, before any key write
        block_q.push_back('0);
        block_q.push_back({128{1'b1}});
        block_q.push_back(128'h00000001_00000000_00000000_80000000);
        queue_random(150);
        wait_idle();

        // standard key and plaintext pair, with a repeat
        load_key(4'hf, 128'h01234567_89abcdef_fedcba98_76543210);
        block_q.push_back(128'h76543210_fedcba98_89abcdef_01234567);
        block_q.push_back(128'h76543210_fedcba98_89abcdef_01234567);
        block_q.push_back('0);
        block_q.push_back({128{1'b1}});
        block_q.push_back(128'h55555555_aaaaaaaa_55555555_aaaaaaaa);
        queue_random(200);
        wait_idle();

        load_key(4'hf, {128{1'b1}});
        block_q.push_back('0);
        block_q.push_back({128{1'b1}});
        queue_random(200);
        wait_idle();

        load_key(4'hf, '0);
        block_q.push_back('0);
        queue_random(150);
        wait_idle();

        // change a single key word at a time
        for (int i = 0; i < 4; i++)
        begin
            load_key(4'(1 << i), {$urandom, $urandom, $urandom, $urandom});
            queue_random(100);
            wait_idle();
        end

        for (int p = 0; p < 4; p++)
        begin
            load_key(4'hf, {$urandom, $urandom, $urandom, $urandom});
            queue_random(100);
            wait_idle();
        end

        repeat (100) @(posedge clk);
        $display("tb: %0d blocks encrypted and checked under %0d key loads", blocks_checked,
                 key_loads);
        $display("tb: reset key, extreme keys, single-word key updates and random keys");
        if (errors == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: timeout after %0d requests", blocks_sent);
        $display("tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
design/sm4_pkg.sv
design/sm4_round_unit.sv
design/sm4_key_ram.sv
design/sm4_block_encrypt.sv
sim/tb.sv
